// ===== sv/pisc_pkg.sv =====
// Shared types, function codes and defaults for the points-in-segments counter.
package pisc_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int COORD_W          = 32;
    localparam int COUNT_W          = 10;
    localparam int FUNC_W           = 2;
    localparam int IN_DATA_W        = 3 * COORD_W;
    localparam int OUT_DATA_W       = 16;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic [FUNC_W-1:0]          func;
        logic signed [COORD_W-1:0]  a;
        logic signed [COORD_W-1:0]  b;
        logic signed [COUNT_W-1:0]  cnt;
        logic                       dropped;
    } token_t;

endpackage

// ===== sv/points_in_segments_counter.sv =====
// Top level of the points-in-segments counter: request entry and the chain of cells.
//
// Requests arrive on the s_ channel: tuser carries the function (clear, load or
// query) and tdata carries the left end, right end and query point. Each request
// gives exactly one result on the m_ channel: tdata holds the signed count of
// left ends at or below the point minus right ends below it (zero for anything
// but a query), and tuser is set when a load found the store full.
// A request walks down a chain of MAX_SEGMENTS cells, one cell per cycle while the
// chain advances, and each cell holds one segment. A load writes its segment when it
// reaches the cell whose index equals the fill count it saw at entry; a query adds
// up the comparisons of every filled cell it passes. The result is registered in
// each cell in turn, and one request is taken every cycle while the receiver does
// not stall; requests keep their order in the chain.
// The last cell's register is the output register. When the receiver stalls,
// the whole chain holds and s_tready drops until the result is taken.
// Reset empties the chain and the store; stored ends are not cleared, as the
// fill count keeps unwritten cells from being read.
module points_in_segments_counter #(
    parameter int MAX_SEGMENTS = pisc_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pisc_pkg::IN_DATA_W-1:0]       s_tdata,   // seg_left, seg_right, query_point
    input  logic [pisc_pkg::FUNC_W-1:0]          s_tuser,   // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pisc_pkg::OUT_DATA_W-1:0]      m_tdata,   // contain_count, zero padding
    output logic                                 m_tuser    // dropped
);
    import pisc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_SEGMENTS);

    token_t           tok [0:MAX_SEGMENTS];
    logic [CNT_W-1:0] lim [0:MAX_SEGMENTS];
    logic [CNT_W-1:0] seg_count_reg;
    logic [CNT_W-1:0] seg_count_next;
    logic             adv;
    logic             accept;
    logic             full;

    assign adv      = !tok[MAX_SEGMENTS].valid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign full     = (seg_count_reg == FULL);

    always_comb
    begin
        tok[0].valid   = s_tvalid;
        tok[0].func    = s_tuser;
        tok[0].a       = s_tdata[COORD_W-1:0];
        tok[0].b       = s_tdata[2*COORD_W-1:COORD_W];
        tok[0].cnt     = '0;
        tok[0].dropped = (s_tuser == FUNC_LOAD) && full;
        if (s_tuser == FUNC_QUERY)
        begin
            tok[0].a = s_tdata[3*COORD_W-1:2*COORD_W];
        end
        lim[0] = seg_count_reg;
    end

    always_comb
    begin
        seg_count_next = seg_count_reg;
        if (accept)
        begin
            unique case (s_tuser)
                FUNC_CLEAR: seg_count_next = '0;
                FUNC_LOAD:
                begin
                    if (!full)
                    begin
                        seg_count_next = seg_count_reg + CNT_W'(1);
                    end
                end
                default: seg_count_next = seg_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= '0;
        end
        else
        begin
            seg_count_reg <= seg_count_next;
        end
    end

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        pisc_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[i]),
            .lim_in  (lim[i]),
            .tok_out (tok[i+1]),
            .lim_out (lim[i+1])
        );
    end

    assign m_tvalid = tok[MAX_SEGMENTS].valid;
    assign m_tdata  = {(OUT_DATA_W - COUNT_W)'(0), tok[MAX_SEGMENTS].cnt};
    assign m_tuser  = tok[MAX_SEGMENTS].dropped;

endmodule

// ===== sv/pisc_cell.sv =====
// One cell of the chain: holds one segment and passes one request per cycle while adv is high.
module pisc_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pisc_pkg::token_t  tok_in,
    input  logic [CNT_W-1:0]  lim_in,
    output pisc_pkg::token_t  tok_out,
    output logic [CNT_W-1:0]  lim_out
);
    import pisc_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

    logic signed [COORD_W-1:0] left_reg;
    logic signed [COORD_W-1:0] right_reg;
    logic                      valid_reg;
    token_t                    data_reg;
    token_t                    data_next;
    logic [CNT_W-1:0]          lim_reg;
    logic                      hit;
    logic                      write_en;

    assign hit      = tok_in.valid && (tok_in.func == FUNC_QUERY) && (IDX < lim_in);
    assign write_en = adv && tok_in.valid && (tok_in.func == FUNC_LOAD) && (lim_in == IDX);

    always_comb
    begin
        data_next = tok_in;
        if (hit)
        begin
            data_next.cnt = tok_in.cnt
                + ((left_reg <= tok_in.a) ? COUNT_W'(1) : COUNT_W'(0))
                - ((right_reg < tok_in.a) ? COUNT_W'(1) : COUNT_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            left_reg  <= tok_in.a;
            right_reg <= tok_in.b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            lim_reg  <= lim_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_comb
    begin
        tok_out       = data_reg;
        tok_out.valid = valid_reg;
    end

    assign lim_out = lim_reg;

endmodule

// ===== sv/pisc_checker.sv =====
// Port-level checks for the points-in-segments counter, bound to the top level.
module pisc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pisc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                              m_tuser
);
    import pisc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output slot");

    a_dropped_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[COUNT_W-1:0] == '0))
        else $error("dropped load carries a count");

    a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:COUNT_W] == '0))
        else $error("result padding is not zero");

endmodule

bind points_in_segments_counter pisc_checker u_pisc_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the points-in-segments counter: predicted counts checked per request.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pisc_pkg::*;

    localparam int SEGMENTS       = MAX_SEGMENTS_DEF;
    localparam real CLK_PERIOD    = 8.0;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = SEGMENTS + 64;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic                      dropped;
    } cover_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    logic signed [COORD_W-1:0] stored_left [SEGMENTS];
    logic signed [COORD_W-1:0] stored_right [SEGMENTS];
    int                        stored_total = 0;

    cover_result_t             expected_covers [$];
    logic signed [COORD_W-1:0] loaded_ends [$];

    int mismatches    = 0;
    int requests_sent = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    points_in_segments_counter #(
        .MAX_SEGMENTS(SEGMENTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        cover_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_covers.size() == 0)
            begin
                $display("%0t: unexpected result, count %0d dropped %0b", $time,
                         $signed(m_tdata[COUNT_W-1:0]), m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_covers.pop_front();
                if (m_tdata[COUNT_W-1:0] !== want.count)
                begin
                    $display("%0t: contain_count expected %0d actual %0d", $time,
                             want.count, $signed(m_tdata[COUNT_W-1:0]));
                    mismatches++;
                end
                if (m_tdata[OUT_DATA_W-1:COUNT_W] !== '0)
                begin
                    $display("%0t: tdata padding expected 0 actual %h", $time,
                             m_tdata[OUT_DATA_W-1:COUNT_W]);
                    mismatches++;
                end
                if (m_tuser !== want.dropped)
                begin
                    $display("%0t: dropped expected %0b actual %0b", $time,
                             want.dropped, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Applies one request to the model of the segment store and returns its result.
    function automatic cover_result_t predict_cover(input logic [FUNC_W-1:0] f,
                                                    input logic signed [COORD_W-1:0] left,
                                                    input logic signed [COORD_W-1:0] right,
                                                    input logic signed [COORD_W-1:0] point);
        cover_result_t res;
        int            total;
        res   = '0;
        total = 0;
        case (f)
            FUNC_CLEAR:
                stored_total = 0;
            FUNC_LOAD:
                if (stored_total < SEGMENTS)
                begin
                    stored_left[stored_total]  = left;
                    stored_right[stored_total] = right;
                    stored_total++;
                end
                else
                    res.dropped = 1'b1;
            FUNC_QUERY:
                for (int k = 0; k < stored_total; k++)
                begin
                    if (stored_left[k] <= point)
                        total++;
                    if (stored_right[k] < point)
                        total--;
                end
            default:
                ;
        endcase
        res.count = COUNT_W'(total);
        return res;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] f,
                                input logic signed [COORD_W-1:0] left,
                                input logic signed [COORD_W-1:0] right,
                                input logic signed [COORD_W-1:0] point);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {point, right, left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_covers.push_back(predict_cover(f, left, right, point));
        if (f != FUNC_UNUSED)
            requests_sent++;
        if (f == FUNC_CLEAR)
            loaded_ends.delete();
        else if (f == FUNC_LOAD)
        begin
            loaded_ends.push_back(left);
            loaded_ends.push_back(right);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_covers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] any_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord();
        logic signed [COORD_W-1:0] v;
        v = $urandom_range(40);
        return v - 20;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_point(input bit wide);
        logic signed [COORD_W-1:0] v;
        if (loaded_ends.size() > 0 && $urandom_range(1) == 0)
        begin
            v = loaded_ends[$urandom_range(loaded_ends.size() - 1)];
            return v + $urandom_range(2) - 1;
        end
        return wide ? any_coord() : near_coord();
    endfunction

    task automatic send_random_load(input bit wide);
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        if (wide)
        begin
            left  = any_coord();
            right = ($urandom_range(3) == 0) ? any_coord() : left + $urandom_range(1000);
        end
        else
        begin
            left  = near_coord();
            right = ($urandom_range(4) == 0) ? near_coord() : left + $urandom_range(8);
        end
        send_request(FUNC_LOAD, left, right, $urandom);
    endtask

    task automatic test_empty_and_unused();
        send_request(FUNC_CLEAR, $urandom, $urandom, $urandom);
        send_request(FUNC_QUERY, $urandom, $urandom, '0);
        send_request(FUNC_QUERY, '0, '0, COORD_MIN);
        send_request(FUNC_UNUSED, $urandom, $urandom, $urandom);
        send_request(FUNC_UNUSED, '1, '1, '1);
    endtask

    task automatic test_edges_and_reversed();
        send_request(FUNC_LOAD, COORD_MIN, COORD_MAX, '0);
        send_request(FUNC_LOAD, '0, '0, '1);
        send_request(FUNC_LOAD, 32'sd5, -32'sd5, '0);
        send_request(FUNC_LOAD, COORD_MAX, COORD_MAX, '0);
        send_request(FUNC_LOAD, COORD_MIN, COORD_MIN, '0);
        send_request(FUNC_QUERY, '0, '0, COORD_MIN);
        send_request(FUNC_QUERY, '1, '1, COORD_MIN + 1);
        send_request(FUNC_QUERY, '0, '0, -32'sd5);
        send_request(FUNC_QUERY, '0, '0, '0);
        send_request(FUNC_QUERY, '0, '0, 32'sd4);
        send_request(FUNC_QUERY, '0, '0, 32'sd5);
        send_request(FUNC_UNUSED, COORD_MIN, COORD_MAX, '0);
        send_request(FUNC_QUERY, '0, '0, -1);
        send_request(FUNC_QUERY, '0, '0, COORD_MAX - 1);
        send_request(FUNC_QUERY, '0, '0, COORD_MAX);
        send_request(FUNC_CLEAR, '1, '1, '1);
        send_request(FUNC_QUERY, '0, '0, '0);
    endtask

    // Fills the store with containing, then with reversed segments, to reach both count limits.
    task automatic test_full_store();
        send_request(FUNC_CLEAR, '0, '0, '0);
        repeat (SEGMENTS)
            send_request(FUNC_LOAD, COORD_MIN, COORD_MAX, $urandom);
        send_request(FUNC_LOAD, '0, '0, '0);
        send_request(FUNC_QUERY, '0, '0, '0);
        send_request(FUNC_QUERY, '0, '0, COORD_MIN);
        send_request(FUNC_QUERY, '0, '0, COORD_MAX);
        wait_results_drained();
        send_request(FUNC_CLEAR, '0, '0, '0);
        repeat (SEGMENTS)
            send_request(FUNC_LOAD, COORD_MAX, COORD_MIN, $urandom);
        send_request(FUNC_LOAD, '1, '1, '1);
        send_request(FUNC_LOAD, COORD_MIN, COORD_MAX, '0);
        send_request(FUNC_QUERY, '0, '0, '0);
        send_request(FUNC_QUERY, '0, '0, COORD_MIN);
        send_request(FUNC_QUERY, '0, '0, COORD_MAX);
        send_request(FUNC_CLEAR, '0, '0, '0);
        send_request(FUNC_LOAD, -32'sd3, 32'sd3, '0);
        send_request(FUNC_QUERY, '0, '0, 32'sd3);
    endtask

    task automatic test_random_traffic(input int n_requests, input int send_idle,
                                       input int recv_stall);
        int goal;
        int n_seg;
        int shape;
        bit wide;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        goal      = requests_sent + n_requests;
        while (requests_sent < goal)
        begin
            if ($urandom_range(9) != 0)
                send_request(FUNC_CLEAR, $urandom, $urandom, $urandom);
            shape = $urandom_range(79);
            if (shape == 0)
                n_seg = SEGMENTS + $urandom_range(1, 3);
            else if (shape < 12)
                n_seg = $urandom_range(13, 40);
            else
                n_seg = $urandom_range(12);
            wide = ($urandom_range(3) == 0);
            repeat (n_seg)
            begin
                if ($urandom_range(29) == 0)
                begin
                    case ($urandom_range(2))
                        0: send_request(FUNC_UNUSED, $urandom, $urandom, $urandom);
                        1: send_request(FUNC_CLEAR, $urandom, $urandom, $urandom);
                        default: send_request(FUNC_QUERY, $urandom, $urandom, any_coord());
                    endcase
                end
                send_random_load(wide);
            end
            repeat ($urandom_range(1, 10))
                send_request(FUNC_QUERY, $urandom, $urandom, pick_point(wide));
        end
        wait_results_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_unused();
        test_edges_and_reversed();
        test_full_store();
        wait_results_drained();
        test_random_traffic(160, 0, 0);
        test_random_traffic(160, 88, 0);
        test_random_traffic(160, 0, 88);
        test_random_traffic(160, 26, 26);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
